// File: rtl/core/cfir_pkg.sv
// Shared types and constants for the complex FIR filter unit.
`default_nettype none
package cfir_pkg;

  // Input command codes
  localparam logic CMD_TAP    = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Fixed field and register widths
  localparam int IDX_BITS = 6;
  localparam int LEN_BITS = 7;
  localparam int OFS_BITS = 6;

  // Configuration port
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam logic CFG_REG_LEN = 1'b0;
  localparam logic CFG_REG_OFS = 1'b1;
  localparam logic [LEN_BITS-1:0] LEN_RESET = 7'd64;
  localparam logic [OFS_BITS-1:0] OFS_RESET = 6'd0;

  // Queue between front and back
  localparam int QDEPTH = 2;

  // Classified operation carried from front to back
  typedef enum logic [1:0] {
    OP_NOP,
    OP_TAP,
    OP_SAMPLE
  } op_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } bk_state_t;

  // Configuration registers as seen by the back end
  typedef struct packed {
    logic [LEN_BITS-1:0] taps_in_use;
    logic [OFS_BITS-1:0] tap_offset;
  } cfir_cfg_t;

endpackage
`default_nettype wire

// File: rtl/core/cfir_in_if.sv
// Input channel: tap writes and sample pushes.
`default_nettype none
interface cfir_in_if #(
  parameter int SAMPLE_BITS = 16,
  parameter int COEFF_BITS  = 16
);
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [5:0]                    tap_index;
  logic signed [COEFF_BITS-1:0]  tap_real;
  logic signed [COEFF_BITS-1:0]  tap_imag;
  logic signed [SAMPLE_BITS-1:0] sample_real;
  logic signed [SAMPLE_BITS-1:0] sample_imag;

  modport source (
    output valid, cmd, tap_index, tap_real, tap_imag, sample_real, sample_imag,
    input  ready
  );
  modport sink (
    input  valid, cmd, tap_index, tap_real, tap_imag, sample_real, sample_imag,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/core/cfir_out_if.sv
// Result channel: one complex filter output per sample.
`default_nettype none
interface cfir_out_if #(
  parameter int OUT_BITS = 39
);
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] out_real;
  logic signed [OUT_BITS-1:0] out_imag;

  modport source (
    output valid, out_real, out_imag,
    input  ready
  );
  modport sink (
    input  valid, out_real, out_imag,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/core/complex_fir_filter_unit.sv
// Complex FIR filter unit: APB registers, front end queue and MAC back end.
// Each sample leaving the queue is multiplied against n taps and summed into one result,
// n = min(taps_in_use, MAX_TAPS) - tap_offset (0 when the offset is too large).
// The back end takes no new queue item until that result is in the output register, as the
// single shared complex multiply-accumulate walks the taps in turn; a tap write is taken in idle.
// Reset (sync, active low): 64 taps / offset 0, window reads zero via a fill count; taps undefined.
`default_nettype none
module complex_fir_filter_unit
  import cfir_pkg::*;
#(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int COEFF_BITS  = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  cfir_in_if.sink                       in_ch,
  cfir_out_if.source                    out_ch,
  input  wire logic                     cfg_psel,
  input  wire logic                     cfg_penable,
  input  wire logic                     cfg_pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output      logic [CFG_DATA_BITS-1:0] cfg_prdata,
  output      logic                     cfg_pready
);
  logic [LEN_BITS-1:0] len_r;
  logic [OFS_BITS-1:0] ofs_r;
  logic                cfg_wr;
  logic                cfg_sel;
  cfir_cfg_t           cfg;

  logic                          q_valid, q_ready;
  op_t                           q_op;
  logic [IDX_BITS-1:0]           q_tap_index;
  logic signed [COEFF_BITS-1:0]  q_tap_real, q_tap_imag;
  logic signed [SAMPLE_BITS-1:0] q_sample_real, q_sample_imag;

  // Register file: word index from the upper address bit
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_sel    = cfg_paddr[CFG_ADDR_BITS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RESET;
      ofs_r <= OFS_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        CFG_REG_LEN: len_r <= cfg_pwdata[LEN_BITS-1:0];
        CFG_REG_OFS: ofs_r <= cfg_pwdata[OFS_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (cfg_sel)
      CFG_REG_LEN: cfg_prdata = CFG_DATA_BITS'(len_r);
      CFG_REG_OFS: cfg_prdata = CFG_DATA_BITS'(ofs_r);
      default:     cfg_prdata = '0;
    endcase
  end

  assign cfg.taps_in_use = len_r;
  assign cfg.tap_offset  = ofs_r;

  cfir_front #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEFF_BITS  (COEFF_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_op          (q_op),
    .q_tap_index   (q_tap_index),
    .q_tap_real    (q_tap_real),
    .q_tap_imag    (q_tap_imag),
    .q_sample_real (q_sample_real),
    .q_sample_imag (q_sample_imag)
  );

  cfir_back #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEFF_BITS  (COEFF_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_op          (q_op),
    .q_tap_index   (q_tap_index),
    .q_tap_real    (q_tap_real),
    .q_tap_imag    (q_tap_imag),
    .q_sample_real (q_sample_real),
    .q_sample_imag (q_sample_imag),
    .out_ch        (out_ch)
  );
endmodule
`default_nettype wire

// File: rtl/core/cfir_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cfir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;
endmodule
`default_nettype wire

// File: rtl/core/cfir_front.sv
// Front end: accepts input transactions, classifies them, and queues them.
`default_nettype none
module cfir_front
  import cfir_pkg::*;
#(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int COEFF_BITS  = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  cfir_in_if.sink                            in_ch,
  output      logic                          q_valid,
  input  wire logic                          q_ready,
  output      op_t                           q_op,
  output      logic [IDX_BITS-1:0]           q_tap_index,
  output      logic signed [COEFF_BITS-1:0]  q_tap_real,
  output      logic signed [COEFF_BITS-1:0]  q_tap_imag,
  output      logic signed [SAMPLE_BITS-1:0] q_sample_real,
  output      logic signed [SAMPLE_BITS-1:0] q_sample_imag
);
  localparam int PTR_BITS = $clog2(QDEPTH);
  localparam int CNT_BITS = $clog2(QDEPTH + 1);

  op_t                           op_r   [QDEPTH];
  logic [IDX_BITS-1:0]           idx_r  [QDEPTH];
  logic signed [COEFF_BITS-1:0]  tre_r  [QDEPTH];
  logic signed [COEFF_BITS-1:0]  tim_r  [QDEPTH];
  logic signed [SAMPLE_BITS-1:0] sre_r  [QDEPTH];
  logic signed [SAMPLE_BITS-1:0] sim_r  [QDEPTH];

  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                push, pop;
  op_t                 op_class;

  // Classify: out-of-range tap writes become no-ops
  always_comb begin
    if (in_ch.cmd == CMD_SAMPLE) begin
      op_class = OP_SAMPLE;
    end else if (32'(in_ch.tap_index) < MAX_TAPS) begin
      op_class = OP_TAP;
    end else begin
      op_class = OP_NOP;
    end
  end

  assign in_ch.ready = (cnt_r != CNT_BITS'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign pop         = q_valid && q_ready;

  // Queue pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      op_r[wr_ptr_r]  <= op_class;
      idx_r[wr_ptr_r] <= in_ch.tap_index;
      tre_r[wr_ptr_r] <= in_ch.tap_real;
      tim_r[wr_ptr_r] <= in_ch.tap_imag;
      sre_r[wr_ptr_r] <= in_ch.sample_real;
      sim_r[wr_ptr_r] <= in_ch.sample_imag;
    end
  end

  assign q_op          = op_r[rd_ptr_r];
  assign q_tap_index   = idx_r[rd_ptr_r];
  assign q_tap_real    = tre_r[rd_ptr_r];
  assign q_tap_imag    = tim_r[rd_ptr_r];
  assign q_sample_real = sre_r[rd_ptr_r];
  assign q_sample_imag = sim_r[rd_ptr_r];
endmodule
`default_nettype wire

// File: rtl/core/cfir_back.sv
// Back end: tap and window storage, shared complex MAC, result register.
`default_nettype none
module cfir_back
  import cfir_pkg::*;
#(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int COEFF_BITS  = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cfir_cfg_t                     cfg,
  input  wire logic                          q_valid,
  output      logic                          q_ready,
  input  wire op_t                           q_op,
  input  wire logic [IDX_BITS-1:0]           q_tap_index,
  input  wire logic signed [COEFF_BITS-1:0]  q_tap_real,
  input  wire logic signed [COEFF_BITS-1:0]  q_tap_imag,
  input  wire logic signed [SAMPLE_BITS-1:0] q_sample_real,
  input  wire logic signed [SAMPLE_BITS-1:0] q_sample_imag,
  cfir_out_if.source                         out_ch
);
  localparam int ADDR_BITS = $clog2(MAX_TAPS);
  localparam int FILL_BITS = ADDR_BITS + 1;
  localparam int CNT_BITS  = (FILL_BITS > LEN_BITS) ? FILL_BITS : LEN_BITS;
  localparam int PROD_BITS = SAMPLE_BITS + COEFF_BITS;
  localparam int OUT_BITS  = PROD_BITS + 1 + ADDR_BITS;

  bk_state_t state_r, state_nxt;

  logic [ADDR_BITS-1:0] newest_r, newest_nxt, newest_inc;
  logic [FILL_BITS-1:0] fill_r, fill_nxt;
  logic [ADDR_BITS-1:0] slot_r, slot_nxt;
  logic [ADDR_BITS-1:0] tap_r, tap_nxt;
  logic [CNT_BITS-1:0]  k_r, k_nxt;
  logic [CNT_BITS-1:0]  n_r, n_nxt;
  logic [CNT_BITS-1:0]  len_ext, len_eff, ofs_ext, taps_cnt;

  logic rd_issue;
  logic rd_vld_r, live_r, live_nxt;
  logic mul_vld_r;

  logic signed [PROD_BITS-1:0] pr_rr_r, pr_ii_r, pr_ri_r, pr_ir_r;
  logic signed [PROD_BITS-1:0] pr_rr_nxt, pr_ii_nxt, pr_ri_nxt, pr_ir_nxt;
  logic signed [OUT_BITS-1:0]  acc_re_r, acc_re_nxt, acc_im_r, acc_im_nxt;
  logic                        out_vld_r, out_vld_nxt;
  logic signed [OUT_BITS-1:0]  out_re_r, out_re_nxt, out_im_r, out_im_nxt;

  logic                          win_we, cf_we;
  logic [2*SAMPLE_BITS-1:0]      win_rd;
  logic [2*COEFF_BITS-1:0]       cf_rd;
  logic signed [SAMPLE_BITS-1:0] smp_re, smp_im;
  logic signed [COEFF_BITS-1:0]  cf_re, cf_im;

  // Sample window and coefficient storage
  cfir_ram #(.WIDTH(2 * SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_win_ram (
    .clk     (clk),
    .we      (win_we),
    .wr_addr (newest_inc),
    .wr_data ({q_sample_real, q_sample_imag}),
    .rd_addr (slot_r),
    .rd_data (win_rd)
  );

  cfir_ram #(.WIDTH(2 * COEFF_BITS), .DEPTH(MAX_TAPS)) u_coef_ram (
    .clk     (clk),
    .we      (cf_we),
    .wr_addr (ADDR_BITS'(q_tap_index)),
    .wr_data ({q_tap_real, q_tap_imag}),
    .rd_addr (tap_r),
    .rd_data (cf_rd)
  );

  // Window entries never filled since reset read as zero
  assign smp_re = live_r ? $signed(win_rd[2*SAMPLE_BITS-1:SAMPLE_BITS]) : '0;
  assign smp_im = live_r ? $signed(win_rd[SAMPLE_BITS-1:0]) : '0;
  assign cf_re  = $signed(cf_rd[2*COEFF_BITS-1:COEFF_BITS]);
  assign cf_im  = $signed(cf_rd[COEFF_BITS-1:0]);

  // Effective tap count: min(taps_in_use, MAX_TAPS) - tap_offset, or zero
  assign len_ext  = CNT_BITS'(cfg.taps_in_use);
  assign len_eff  = (len_ext > CNT_BITS'(MAX_TAPS)) ? CNT_BITS'(MAX_TAPS) : len_ext;
  assign ofs_ext  = CNT_BITS'(cfg.tap_offset);
  assign taps_cnt = (ofs_ext < len_eff) ? (len_eff - ofs_ext) : '0;

  assign newest_inc = (newest_r == ADDR_BITS'(MAX_TAPS - 1)) ? '0 : newest_r + 1'b1;

  // Sequencer and datapath next state
  always_comb begin
    state_nxt   = state_r;
    newest_nxt  = newest_r;
    fill_nxt    = fill_r;
    slot_nxt    = slot_r;
    tap_nxt     = tap_r;
    k_nxt       = k_r;
    n_nxt       = n_r;
    q_ready     = 1'b0;
    win_we      = 1'b0;
    cf_we       = 1'b0;
    rd_issue    = 1'b0;
    out_re_nxt  = out_re_r;
    out_im_nxt  = out_im_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;

    // MAC pipeline: read, multiply, accumulate
    live_nxt  = (CNT_BITS'(fill_r) > k_r);
    pr_rr_nxt = smp_re * cf_re;
    pr_ii_nxt = smp_im * cf_im;
    pr_ri_nxt = smp_re * cf_im;
    pr_ir_nxt = smp_im * cf_re;
    acc_re_nxt = acc_re_r;
    acc_im_nxt = acc_im_r;
    if (mul_vld_r) begin
      acc_re_nxt = acc_re_r + OUT_BITS'(pr_rr_r) - OUT_BITS'(pr_ii_r);
      acc_im_nxt = acc_im_r + OUT_BITS'(pr_ri_r) + OUT_BITS'(pr_ir_r);
    end

    unique case (state_r)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          unique case (q_op)
            OP_TAP: begin
              cf_we = 1'b1;
            end
            OP_SAMPLE: begin
              win_we     = 1'b1;
              newest_nxt = newest_inc;
              fill_nxt   = (fill_r == FILL_BITS'(MAX_TAPS)) ? fill_r : fill_r + 1'b1;
              slot_nxt   = newest_inc;
              tap_nxt    = ADDR_BITS'(cfg.tap_offset);
              k_nxt      = '0;
              n_nxt      = taps_cnt;
              acc_re_nxt = '0;
              acc_im_nxt = '0;
              state_nxt  = (taps_cnt == '0) ? ST_DONE : ST_RUN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        rd_issue = 1'b1;
        slot_nxt = (slot_r == '0) ? ADDR_BITS'(MAX_TAPS - 1) : slot_r - 1'b1;
        tap_nxt  = tap_r + 1'b1;
        k_nxt    = k_r + 1'b1;
        if (k_r == n_r - 1'b1) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_r && !mul_vld_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hand the sum to the output register once it is free
        if (!out_vld_r || out_ch.ready) begin
          out_vld_nxt = 1'b1;
          out_re_nxt  = acc_re_r;
          out_im_nxt  = acc_im_r;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      newest_r  <= '0;
      fill_r    <= '0;
      rd_vld_r  <= 1'b0;
      mul_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      newest_r  <= newest_nxt;
      fill_r    <= fill_nxt;
      rd_vld_r  <= rd_issue;
      mul_vld_r <= rd_vld_r;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    slot_r   <= slot_nxt;
    tap_r    <= tap_nxt;
    k_r      <= k_nxt;
    n_r      <= n_nxt;
    live_r   <= live_nxt;
    pr_rr_r  <= pr_rr_nxt;
    pr_ii_r  <= pr_ii_nxt;
    pr_ri_r  <= pr_ri_nxt;
    pr_ir_r  <= pr_ir_nxt;
    acc_re_r <= acc_re_nxt;
    acc_im_r <= acc_im_nxt;
    out_re_r <= out_re_nxt;
    out_im_r <= out_im_nxt;
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.out_real = out_re_r;
  assign out_ch.out_imag = out_im_r;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_BITS'(MAX_TAPS))
    else $error("window fill count above depth");

  a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> k_r < n_r)
    else $error("tap counter ran past tap count");

  a_mul_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    mul_vld_r |-> $past(rd_vld_r))
    else $error("product without a preceding read");

  a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |-> !rd_vld_r && !mul_vld_r)
    else $error("result taken while MAC pipeline busy");
`endif
endmodule
`default_nettype wire

// File: dv/complex_fir_filter_unit_tb.sv
// Testbench for complex_fir_filter_unit: directed and random traffic checked by a predictor.
module complex_fir_filter_unit_tb;
  import cfir_pkg::*;

  localparam int TAPS     = 64;
  localparam int SMP_BITS = 16;
  localparam int CF_BITS  = 16;
  localparam int OUT_BITS = 39;

  // One input transaction and one filter output
  typedef struct {
    logic                       cmd;
    logic [IDX_BITS-1:0]        tap_index;
    logic signed [CF_BITS-1:0]  tap_real;
    logic signed [CF_BITS-1:0]  tap_imag;
    logic signed [SMP_BITS-1:0] sample_real;
    logic signed [SMP_BITS-1:0] sample_imag;
  } fir_req_t;

  typedef struct {
    logic signed [OUT_BITS-1:0] out_real;
    logic signed [OUT_BITS-1:0] out_imag;
  } fir_res_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                     cfg_psel;
  logic                     cfg_penable;
  logic                     cfg_pwrite;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr;
  logic [CFG_DATA_BITS-1:0] cfg_pwdata;
  logic [CFG_DATA_BITS-1:0] cfg_prdata;
  logic                     cfg_pready;

  cfir_in_if  #(.SAMPLE_BITS(SMP_BITS), .COEFF_BITS(CF_BITS)) in_ch ();
  cfir_out_if #(.OUT_BITS(OUT_BITS)) out_ch ();

  complex_fir_filter_unit #(
    .MAX_TAPS    (TAPS),
    .SAMPLE_BITS (SMP_BITS),
    .COEFF_BITS  (CF_BITS)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Clock, period 20
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: sample window, coefficients, registers
  logic signed [SMP_BITS-1:0] win_re [TAPS] = '{default: '0};
  logic signed [SMP_BITS-1:0] win_im [TAPS] = '{default: '0};
  logic signed [CF_BITS-1:0]  coef_re [TAPS];
  logic signed [CF_BITS-1:0]  coef_im [TAPS];
  logic [IDX_BITS-1:0]        newest_slot = '0;
  logic [LEN_BITS-1:0]        len_cfg = LEN_RESET;
  logic [OFS_BITS-1:0]        ofs_cfg = OFS_RESET;

  // Expected outputs, oldest at due_head
  fir_res_t    due_fifo [256];
  int unsigned due_head = 0;
  int unsigned due_tail = 0;
  fir_res_t    due_res;
  int unsigned mismatch_cnt = 0;
  int unsigned tx_idle_pct  = 8;
  int unsigned rx_stall_pct = 54;

  // Update predictor with one transaction; a sample push queues its filter output
  function automatic void model_item(input fir_req_t req);
    int unsigned    eff_len;
    int unsigned    t;
    logic [IDX_BITS-1:0] slot;
    longint         acc_re;
    longint         acc_im;
    fir_res_t       res;
    if (req.cmd == CMD_TAP) begin
      coef_re[req.tap_index] = req.tap_real;
      coef_im[req.tap_index] = req.tap_imag;
      return;
    end
    newest_slot = newest_slot + 1'b1;
    win_re[newest_slot] = req.sample_real;
    win_im[newest_slot] = req.sample_imag;
    eff_len = (len_cfg > TAPS) ? TAPS : len_cfg;
    acc_re = 0;
    acc_im = 0;
    slot = newest_slot;
    // newest sample meets tap ofs_cfg, older samples meet higher taps
    for (t = ofs_cfg; t < eff_len; t++) begin
      acc_re += longint'(win_re[slot]) * coef_re[t] - longint'(win_im[slot]) * coef_im[t];
      acc_im += longint'(win_re[slot]) * coef_im[t] + longint'(win_im[slot]) * coef_re[t];
      slot = slot - 1'b1;
    end
    res.out_real = acc_re[OUT_BITS-1:0];
    res.out_imag = acc_im[OUT_BITS-1:0];
    due_fifo[due_tail[7:0]] = res;
    due_tail++;
  endfunction

  function automatic fir_req_t rand_req(input logic cmd);
    fir_req_t r;
    r.cmd         = cmd;
    r.tap_index   = IDX_BITS'($urandom);
    r.tap_real    = CF_BITS'($urandom);
    r.tap_imag    = CF_BITS'($urandom);
    r.sample_real = SMP_BITS'($urandom);
    r.sample_imag = SMP_BITS'($urandom);
    return r;
  endfunction

  // Drive one transaction, holding valid until accepted
  task automatic send_item(input fir_req_t req);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= req.cmd;
    in_ch.tap_index   <= req.tap_index;
    in_ch.tap_real    <= req.tap_real;
    in_ch.tap_imag    <= req.tap_imag;
    in_ch.sample_real <= req.sample_real;
    in_ch.sample_imag <= req.sample_imag;
    model_item(req);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_tap(input int idx, input int re, input int im);
    fir_req_t r;
    r = rand_req(CMD_TAP);
    r.tap_index = idx[IDX_BITS-1:0];
    r.tap_real  = re[CF_BITS-1:0];
    r.tap_imag  = im[CF_BITS-1:0];
    send_item(r);
  endtask

  task automatic send_sample(input int re, input int im);
    fir_req_t r;
    r = rand_req(CMD_SAMPLE);
    r.sample_real = re[SMP_BITS-1:0];
    r.sample_imag = im[SMP_BITS-1:0];
    send_item(r);
  endtask

  // Stop sending, wait for every queued output, then let tap writes settle
  task automatic wait_idle(input int unsigned settle);
    in_ch.valid <= 1'b0;
    while (due_tail != due_head) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // APB write of one register, then read it back
  task automatic program_reg(input logic reg_sel, input int unsigned field);
    logic [CFG_DATA_BITS-1:0] want;
    logic [CFG_DATA_BITS-1:0] junk;
    junk = $urandom;
    if (reg_sel == CFG_REG_LEN) begin
      want = field & ((1 << LEN_BITS) - 1);
      junk = (junk << LEN_BITS) | want;
    end else begin
      want = field & ((1 << OFS_BITS) - 1);
      junk = (junk << OFS_BITS) | want;
    end
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_sel, 2'b00};
    cfg_pwdata  <= junk;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    // read back, upper write bits must be dropped
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== want) begin
      $display("%0t: register %0d readback expected %0h actual %0h",
               $time, reg_sel, want, cfg_prdata);
      mismatch_cnt++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (reg_sel == CFG_REG_LEN) len_cfg = want[LEN_BITS-1:0];
    else ofs_cfg = want[OFS_BITS-1:0];
  endtask

  // Receiver backpressure
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Output checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_tail == due_head) begin
        $display("%0t: unexpected output, expected none, actual re=%0d im=%0d",
                 $time, out_ch.out_real, out_ch.out_imag);
        mismatch_cnt++;
      end else begin
        due_res = due_fifo[due_head[7:0]];
        due_head++;
        if (out_ch.out_real !== due_res.out_real) begin
          $display("%0t: out_real expected %0d actual %0d",
                   $time, due_res.out_real, out_ch.out_real);
          mismatch_cnt++;
        end
        if (out_ch.out_imag !== due_res.out_imag) begin
          $display("%0t: out_imag expected %0d actual %0d",
                   $time, due_res.out_imag, out_ch.out_imag);
          mismatch_cnt++;
        end
      end
    end
  end

  // Short window with full-scale taps and samples, incl. the partly filled window
  task automatic test_basic_taps();
    program_reg(CFG_REG_LEN, 4);
    program_reg(CFG_REG_OFS, 0);
    send_tap(0, 32767, -32768);
    send_tap(1, -32768, -32768);
    send_tap(2, -32768, 32767);
    send_tap(3, 1, -1);
    send_sample(32767, -32768);
    send_sample(-32768, -32768);
    send_sample(-32768, 32767);
    send_sample(0, 0);
    send_sample(-1, 1);
  endtask

  // Offset past the window, zero length, saturated length, length raised mid-stream
  task automatic test_window_edges();
    wait_idle(16);
    program_reg(CFG_REG_OFS, 4);
    send_sample($urandom, $urandom);
    wait_idle(16);
    program_reg(CFG_REG_OFS, 63);
    send_sample($urandom, $urandom);
    wait_idle(16);
    program_reg(CFG_REG_LEN, 0);
    program_reg(CFG_REG_OFS, 0);
    send_sample($urandom, $urandom);
    send_tap(63, -32768, -32768);
    wait_idle(16);
    program_reg(CFG_REG_LEN, 127);
    program_reg(CFG_REG_OFS, 63);
    send_sample(-32768, -32768);
    wait_idle(16);
    program_reg(CFG_REG_LEN, 2);
    program_reg(CFG_REG_OFS, 0);
    send_sample($urandom, $urandom);
    send_sample($urandom, $urandom);
    wait_idle(16);
    // older samples come back into the window
    program_reg(CFG_REG_LEN, 4);
    send_sample($urandom, $urandom);
  endtask

  // Every tap gets a value before random traffic reads it
  task automatic test_tap_load();
    for (int i = 0; i < TAPS; i++) send_tap(i, $urandom, $urandom);
  endtask

  // Random taps and samples under a series of register settings
  task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                     input int unsigned epochs);
    int unsigned len_pick;
    int unsigned eff_len;
    int unsigned ofs_pick;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (epochs) begin
      wait_idle(16);
      case ($urandom_range(9))
        0:       len_pick = 0;
        1:       len_pick = $urandom_range(127, TAPS + 1);
        2:       len_pick = TAPS;
        3:       len_pick = $urandom_range(TAPS - 1, 9);
        default: len_pick = $urandom_range(8, 1);
      endcase
      eff_len = (len_pick > TAPS) ? TAPS : len_pick;
      if (eff_len > 0 && $urandom_range(3) != 0) ofs_pick = $urandom_range(eff_len - 1, 0);
      else ofs_pick = $urandom_range(63, 0);
      program_reg(CFG_REG_LEN, len_pick);
      program_reg(CFG_REG_OFS, ofs_pick);
      repeat (49) send_item(rand_req(($urandom_range(3) != 0) ? CMD_SAMPLE : CMD_TAP));
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.cmd         <= CMD_TAP;
    in_ch.tap_index   <= '0;
    in_ch.tap_real    <= '0;
    in_ch.tap_imag    <= '0;
    in_ch.sample_real <= '0;
    in_ch.sample_imag <= '0;
    cfg_psel          <= 1'b0;
    cfg_penable       <= 1'b0;
    cfg_pwrite        <= 1'b0;
    cfg_paddr         <= '0;
    cfg_pwdata        <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_taps();
    test_window_edges();
    test_tap_load();
    test_random_traffic(8, 54, 10);
    test_random_traffic(54, 8, 10);
    test_random_traffic(0, 0, 10);

    wait_idle(80);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
